// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the decoder's parser module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rld_pkg.sv =====
// ---------------------------------------------------------------------------
// rld_pkg
// Types, codes and palette curves of the run-length image decoder.
// ---------------------------------------------------------------------------
package rld_pkg;

  // Result kinds.
  localparam logic [1:0] RK_RUN   = 2'd0;
  localparam logic [1:0] RK_ERROR = 2'd1;
  localparam logic [1:0] RK_EMPTY = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_TOO_SMALL  = 3'd0;
  localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
  localparam logic [2:0] ERR_END_DATA   = 3'd2;
  localparam logic [2:0] ERR_BUDGET     = 3'd3;
  localparam logic [2:0] ERR_ZERO_COUNT = 3'd4;

  // Fourth header byte.
  localparam logic [7:0] HEADER_MARK = 8'h80;

  // One classified input item as it travels through the queue.
  typedef struct packed {
    logic       is_new;
    logic [7:0] data_byte;
    logic       too_short;
  } q_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] err;
    logic [7:0] pal;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run_len;
    logic [7:0] row;
    logic [7:0] col;
    logic       img_end;
  } result_t;

  // Red level of the 3-bit red field.
  function automatic logic [7:0] red_level(input logic [2:0] idx);
    logic [7:0] lvl;
    unique case (idx)
      3'd0: lvl = 8'd0;
      3'd1: lvl = 8'd8;
      3'd2: lvl = 8'd24;
      3'd3: lvl = 8'd57;
      3'd4: lvl = 8'd99;
      3'd5: lvl = 8'd123;
      3'd6: lvl = 8'd214;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // Green level of the 3-bit green field.
  function automatic logic [7:0] green_level(input logic [2:0] idx);
    logic [7:0] lvl;
    unique case (idx)
      3'd0: lvl = 8'd0;
      3'd1: lvl = 8'd12;
      3'd2: lvl = 8'd24;
      3'd3: lvl = 8'd48;
      3'd4: lvl = 8'd85;
      3'd5: lvl = 8'd125;
      3'd6: lvl = 8'd170;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // Blue level of the 2-bit blue field.
  function automatic logic [7:0] blue_level(input logic [1:0] idx);
    logic [7:0] lvl;
    unique case (idx)
      2'd0: lvl = 8'd0;
      2'd1: lvl = 8'd66;
      2'd2: lvl = 8'd132;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  // Result that carries only a kind and an error code.
  function automatic result_t plain_result(input logic [1:0] kind, input logic [2:0] err);
    result_t res;
    res = '0;
    res.kind = kind;
    res.err = err;
    return res;
  endfunction

endpackage

// ===== rtl/core/rle_row_image_decoder.sv =====
// ---------------------------------------------------------------------------
// rle_row_image_decoder
// Run-length decoder for an 8-bit palette image arriving one byte per item.
// ---------------------------------------------------------------------------
// The decoder takes one stream byte per clock cycle, sustained, while the
// output is not stalled, and gives at most one result item per input item.
// A byte goes into a two-entry queue when it is accepted and is parsed in a
// following cycle; its result item passes through the queue and then the
// result register before it is presented. The rate is set by the parser,
// which handles one byte per cycle unless a full result register is stalled;
// during an output stall the queue keeps taking input bytes until it has
// filled. A byte with tuser set starts a new resource and abandons any image
// in progress.
// ---------------------------------------------------------------------------
module rle_row_image_decoder #(
  parameter int SIZE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte [7:0], total_size [31:8]
  input  logic [31:0] s_axis_tdata,
  // kind [0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // error_code [2:0], palette_index [10:3], red [18:11], green [26:19],
  // blue [34:27], run_length [42:35], row_number [50:43],
  // start_column [58:51], zero [63:59]
  output logic [63:0] m_axis_tdata,
  // result_kind [1:0]
  output logic [1:0]  m_axis_tuser,
  // image_end
  output logic        m_axis_tlast
);
  import rld_pkg::*;

  logic                 q_valid;
  logic                 q_ready;
  q_item_t              q_item;
  logic [SIZE_BITS-1:0] q_left;
  result_t              out_res;

  // Input side: classification and queue.
  rld_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser[0]),
    .in_byte  (s_axis_tdata[7:0]),
    .in_total (s_axis_tdata[31:8]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .q_left   (q_left)
  );

  // Parsing side with the result register.
  rld_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .q_left    (q_left),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result item onto the output stream.
  assign m_axis_tdata = {5'd0, out_res.col, out_res.row, out_res.run_len, out_res.blue,
                         out_res.green, out_res.red, out_res.pal, out_res.err};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.img_end;

endmodule

// ===== rtl/core/rld_front.sv =====
// ---------------------------------------------------------------------------
// rld_front
// Accepts stream items, classifies resource starts and queues them.
// ---------------------------------------------------------------------------
module rld_front #(
  parameter int SIZE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [7:0]           in_byte,
  input  logic [23:0]          in_total,
  output logic                 q_valid,
  input  logic                 q_ready,
  output rld_pkg::q_item_t     q_item,
  output logic [SIZE_BITS-1:0] q_left
);
  import rld_pkg::*;

  localparam logic [32:0] SizeCap = (33'd1 << SIZE_BITS) - 33'd1;

  q_item_t              item_mem [2];
  logic [SIZE_BITS-1:0] left_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 pop;
  logic [32:0]          total_wide;
  logic [32:0]          total_sat;
  q_item_t              new_item;
  logic [SIZE_BITS-1:0] new_left;

  // Saturate the resource size and work out what is left after the header.
  always_comb begin
    total_wide = {9'd0, in_total};
    total_sat = (total_wide > SizeCap) ? SizeCap : total_wide;
    new_item.is_new = in_kind;
    new_item.data_byte = in_byte;
    new_item.too_short = (total_sat < 33'd4);
    new_left = total_sat[SIZE_BITS-1:0] - SIZE_BITS'(4);
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = item_mem[rd_ptr];
  assign q_left = left_mem[rd_ptr];

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      item_mem[wr_ptr] <= new_item;
      left_mem[wr_ptr] <= new_left;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/rld_parser.sv =====
// ---------------------------------------------------------------------------
// rld_parser
// Parses the header, row counts and RLE data and registers the results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rld_parser #(
  parameter int SIZE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rld_pkg::q_item_t     q_item,
  input  logic [SIZE_BITS-1:0] q_left,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rld_pkg::result_t     out_res
);
  import rld_pkg::*;

  // Parse phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_COUNT_LO = 3'd2;
  localparam logic [2:0] PH_COUNT_HI = 3'd3;
  localparam logic [2:0] PH_PIXEL    = 3'd4;
  localparam logic [2:0] PH_SKIP     = 3'd5;

  logic [2:0]           phase, phase_next;
  logic [1:0]           esc, esc_next;
  logic [7:0]           width, width_next;
  logic [7:0]           height, height_next;
  logic [7:0]           row, row_next;
  logic [7:0]           col, col_next;
  logic [SIZE_BITS-1:0] left, left_next;
  logic [15:0]          row_left, row_left_next;
  logic signed [16:0]   budget, budget_next;
  logic [7:0]           esc_val, esc_val_next;
  logic [7:0]           len_lo, len_lo_next;

  logic                 pop;
  logic                 emit;
  result_t              res;
  logic                 run_go;
  logic [7:0]           b;
  logic [7:0]           room;
  logic [7:0]           run_cnt;
  logic [7:0]           run_val;
  logic [7:0]           run;
  logic [7:0]           col_end;
  logic [7:0]           row_inc;
  logic [15:0]          row_left_dec;
  logic signed [16:0]   budget_dec1;
  logic signed [16:0]   budget_dec2;
  logic signed [16:0]   budget_after;
  logic [15:0]          len;
  logic [15:0]          used;
  logic signed [16:0]   budget_row;

  // A byte is taken whenever the result register is free or being emptied.
  assign q_ready = !out_valid || out_ready;
  assign pop = q_valid && q_ready;

  // Shared arithmetic of runs, rows and budgets.
  always_comb begin
    b = q_item.data_byte;
    room = width - col;
    run_cnt = (esc == 2'd0) ? 8'd1 : b;
    run_val = (esc == 2'd0) ? b : esc_val;
    run = (run_cnt < room) ? run_cnt : room;
    col_end = col + run;
    row_inc = row + 8'd1;
    row_left_dec = row_left - {15'd0, (row_left != 16'd0)};
    budget_dec1 = budget - 17'sd1;
    budget_dec2 = budget - 17'sd2;
    budget_after = (esc == 2'd0) ? budget_dec1 : budget_dec2;
    len = {b, len_lo};
    used = (len < 16'd2) ? 16'd2 : len;
    budget_row = $signed({1'b0, len}) - 17'sd4;
  end

  // Next state and result of the byte at the head of the queue.
  always_comb begin
    phase_next = phase;
    esc_next = esc;
    width_next = width;
    height_next = height;
    row_next = row;
    col_next = col;
    left_next = left;
    row_left_next = row_left;
    budget_next = budget;
    esc_val_next = esc_val;
    len_lo_next = len_lo;
    emit = 1'b0;
    res = '0;
    run_go = 1'b0;
    if (pop) begin
      if (q_item.is_new) begin
        // A new resource always restarts the decoder.
        esc_next = 2'd0;
        phase_next = PH_IDLE;
        height_next = 8'd0;
        row_next = 8'd0;
        col_next = 8'd0;
        if (q_item.too_short) begin
          emit = 1'b1;
          res = plain_result(RK_ERROR, ERR_TOO_SMALL);
        end else begin
          width_next = b;
          left_next = q_left;
          esc_next = 2'd1;
          phase_next = PH_HEADER;
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (esc == 2'd1) begin
              len_lo_next = {7'd0, (b != 8'd0)};
              esc_next = 2'd2;
            end else if (esc == 2'd2) begin
              height_next = b;
              esc_next = 2'd3;
            end else if (len_lo != 8'd0 || b != HEADER_MARK) begin
              emit = 1'b1;
              res = plain_result(RK_ERROR, ERR_BAD_HEADER);
              phase_next = PH_IDLE;
            end else if (height == 8'd0) begin
              emit = 1'b1;
              res = plain_result(RK_EMPTY, ERR_TOO_SMALL);
              phase_next = PH_IDLE;
            end else begin
              len_lo_next = 8'd0;
              esc_next = 2'd0;
              row_next = 8'd0;
              phase_next = PH_COUNT_LO;
            end
          end
          PH_COUNT_LO: begin
            len_lo_next = b;
            phase_next = PH_COUNT_HI;
          end
          PH_COUNT_HI: begin
            if (left < SIZE_BITS'(used)) begin
              emit = 1'b1;
              res = plain_result(RK_ERROR, ERR_END_DATA);
              phase_next = PH_IDLE;
            end else begin
              left_next = left - SIZE_BITS'(used);
              row_left_next = used - 16'd2;
              budget_next = budget_row;
              col_next = 8'd0;
              esc_next = 2'd0;
              if (width == 8'd0) begin
                // An empty row finishes as soon as its count is read.
                row_next = row_inc;
                if (row_inc == height) begin
                  emit = 1'b1;
                  res = plain_result(RK_EMPTY, ERR_TOO_SMALL);
                  phase_next = PH_IDLE;
                end else begin
                  phase_next = (used == 16'd2) ? PH_COUNT_LO : PH_SKIP;
                end
              end else if (budget_row < 17'sd1) begin
                emit = 1'b1;
                res = plain_result(RK_ERROR, ERR_BUDGET);
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_PIXEL;
              end
            end
          end
          PH_PIXEL: begin
            row_left_next = row_left_dec;
            if (esc == 2'd0) begin
              budget_next = budget_dec1;
              if (b != 8'd0) begin
                run_go = 1'b1;
              end else if (budget_dec1 < 17'sd2) begin
                emit = 1'b1;
                res = plain_result(RK_ERROR, ERR_BUDGET);
                phase_next = PH_IDLE;
              end else begin
                esc_next = 2'd1;
              end
            end else if (esc == 2'd1) begin
              esc_val_next = b;
              esc_next = 2'd2;
            end else begin
              budget_next = budget_dec2;
              esc_next = 2'd0;
              if (b == 8'd0) begin
                emit = 1'b1;
                res = plain_result(RK_ERROR, ERR_ZERO_COUNT);
                phase_next = PH_IDLE;
              end else begin
                run_go = 1'b1;
              end
            end
            // Emit a run, clipped at the row end, or a budget error if the row is unfinished and the budget is spent.
            if (run_go) begin
              emit = 1'b1;
              res.kind = RK_RUN;
              res.pal = run_val;
              res.red = red_level(run_val[7:5]);
              res.green = green_level(run_val[4:2]);
              res.blue = blue_level(run_val[1:0]);
              res.run_len = run;
              res.row = row;
              res.col = col;
              col_next = col_end;
              if (col_end == width) begin
                row_next = row_inc;
                col_next = 8'd0;
                if (row_inc == height) begin
                  res.img_end = 1'b1;
                  phase_next = PH_IDLE;
                end else begin
                  phase_next = (row_left_dec == 16'd0) ? PH_COUNT_LO : PH_SKIP;
                  esc_next = 2'd0;
                end
              end else if (budget_after < 17'sd1) begin
                res = plain_result(RK_ERROR, ERR_BUDGET);
                phase_next = PH_IDLE;
              end
            end
          end
          PH_SKIP: begin
            row_left_next = row_left_dec;
            if (row_left_dec == 16'd0) begin
              phase_next = PH_COUNT_LO;
            end
          end
          default: begin
            // Data bytes are ignored while idle.
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      esc <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      esc <= esc_next;
      if (pop) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Image geometry, counters and the result register.
  always_ff @(posedge clk) begin
    width <= width_next;
    height <= height_next;
    row <= row_next;
    col <= col_next;
    left <= left_next;
    row_left <= row_left_next;
    budget <= budget_next;
    esc_val <= esc_val_next;
    len_lo <= len_lo_next;
    if (pop && emit) begin
      out_res <= res;
    end
  end

  `ASSERT_IMPLIES(a_pixel_col, clk, rst, phase == PH_PIXEL, col < width,
    "Column reached the row width while pixels were still expected.")
  `ASSERT_IMPLIES(a_pixel_budget, clk, rst, phase == PH_PIXEL, budget > 17'sd0,
    "Row budget ran out while pixels were still expected.")
  `ASSERT_IMPLIES(a_plain_fields, clk, rst, out_valid && out_res.kind != RK_RUN,
    out_res.run_len == 8'd0 && !out_res.img_end,
    "A result that is not a run carries run fields.")
  `ASSERT_NEXT(a_new_header, clk, rst, pop && q_item.is_new && !q_item.too_short,
    phase == PH_HEADER && esc == 2'd1,
    "A valid resource start did not enter header parsing.")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Run-length image decoder testbench
// Streams resource bytes into the decoder and checks every result item
// against a cycle-free model of the header, row and run parsing, with
// random idling on both sides and long output stalls.
// ----------------------------------------------------------------------------
module testbench;
  import rld_pkg::*;

  localparam int IDLE_PCT     = 36;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_A       = 600;
  localparam int HOLD_B       = 1800;
  localparam int HOLD_LEN     = 300;
  localparam int CALM_FROM    = 1000;
  localparam int CALM_TO      = 1500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  // Palette curves, one byte per level, lowest level in the lowest byte.
  localparam logic [63:0] RED_STEPS   = {8'd255, 8'd214, 8'd123, 8'd99,
                                         8'd57, 8'd24, 8'd8, 8'd0};
  localparam logic [63:0] GREEN_STEPS = {8'd255, 8'd170, 8'd125, 8'd85,
                                         8'd48, 8'd24, 8'd12, 8'd0};
  localparam logic [31:0] BLUE_STEPS  = {8'd255, 8'd132, 8'd66, 8'd0};

  typedef enum logic [2:0] {
    ST_IDLE, ST_HEADER, ST_LEN_LO, ST_LEN_HI, ST_PIXELS, ST_SKIP
  } dec_phase_e;

  typedef enum int {
    FLAW_NONE, FLAW_SHORT, FLAW_CORRUPT, FLAW_ZERO_COUNT, FLAW_CUT,
    FLAW_HEADER, FLAW_BUDGET
  } flaw_e;

  typedef struct {
    bit          is_new;
    logic [7:0]  data;
    logic [23:0] total;
  } feed_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // data_byte [7:0], total_size [31:8]
  logic [31:0] s_axis_tdata = '0;
  // kind [0]
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // error_code [2:0], palette_index [10:3], red [18:11], green [26:19],
  // blue [34:27], run_length [42:35], row_number [50:43],
  // start_column [58:51], zero [63:59]
  logic [63:0] m_axis_tdata;
  // result_kind [1:0]
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  feed_item_t byte_feed[$];
  result_t    pending_results[$];

  int cycle_no     = 0;
  int hold_left    = 0;
  int stall_cycles = 0;
  int failures     = 0;
  int bytes_in     = 0;
  int runs_seen    = 0;
  int errors_seen  = 0;
  int empties_seen = 0;
  int images_made  = 0;
  logic calm_window;

  // Decoder model state.
  dec_phase_e  dec_phase = ST_IDLE;
  logic [7:0]  img_w = '0;
  logic [7:0]  img_h = '0;
  logic [7:0]  row_no = '0;
  logic [7:0]  col_no = '0;
  logic [31:0] data_left = '0;
  logic [15:0] row_left = '0;
  int          budget = 0;
  logic [7:0]  esc_val = '0;
  logic [7:0]  len_lo = '0;
  logic [1:0]  esc_step = '0;

  rle_row_image_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  assign calm_window = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // A result with only a kind and a code ends the image.
  task automatic set_plain(output result_t res, input logic [1:0] k, input logic [2:0] code);
    res = '0;
    res.kind = k;
    res.err = code;
    dec_phase = ST_IDLE;
  endtask

  // Advances to the next row; returns 1 when the image is complete.
  function automatic bit close_row();
    row_no = row_no + 8'd1;
    col_no = '0;
    if (row_no == img_h) begin
      dec_phase = ST_IDLE;
      return 1'b1;
    end
    dec_phase = (row_left == 0) ? ST_LEN_LO : ST_SKIP;
    esc_step = '0;
    return 1'b0;
  endfunction

  // Emits a run clipped at the row end, or a budget error if the row is
  // unfinished and the budget is spent.
  task automatic emit_pixels(input logic [7:0] val, input int count, output result_t res);
    int room;
    int run;
    bit done;
    room = int'(img_w) - int'(col_no);
    run = (count < room) ? count : room;
    res = '0;
    res.kind = RK_RUN;
    res.pal = val;
    res.red = RED_STEPS[val[7:5]*8 +: 8];
    res.green = GREEN_STEPS[val[4:2]*8 +: 8];
    res.blue = BLUE_STEPS[val[1:0]*8 +: 8];
    res.run_len = run[7:0];
    res.row = row_no;
    res.col = col_no;
    col_no = col_no + run[7:0];
    done = 1'b0;
    if (col_no == img_w) begin
      done = close_row();
    end else if (budget < 1) begin
      set_plain(res, RK_ERROR, ERR_BUDGET);
      return;
    end
    res.img_end = done;
  endtask

  // Works out the result, if any, that one accepted byte causes.
  task automatic decode_byte(input bit is_new, input logic [7:0] b, input logic [23:0] total,
                             output bit produced, output result_t res);
    int row_len;
    int used;
    produced = 1'b0;
    res = '0;
    if (is_new) begin
      dec_phase = ST_IDLE;
      img_w = '0;
      img_h = '0;
      row_no = '0;
      col_no = '0;
      data_left = '0;
      row_left = '0;
      budget = 0;
      esc_val = '0;
      len_lo = '0;
      esc_step = '0;
      if (total < 4) begin
        set_plain(res, RK_ERROR, ERR_TOO_SMALL);
        produced = 1'b1;
      end else begin
        img_w = b;
        data_left = 32'(total) - 32'd4;
        esc_step = 2'd1;
        dec_phase = ST_HEADER;
      end
      return;
    end
    case (dec_phase)
      ST_HEADER: begin
        if (esc_step == 2'd1) begin
          len_lo = {7'd0, b != 8'd0};
          esc_step = 2'd2;
        end else if (esc_step == 2'd2) begin
          img_h = b;
          esc_step = 2'd3;
        end else if (len_lo != 0 || b != HEADER_MARK) begin
          set_plain(res, RK_ERROR, ERR_BAD_HEADER);
          produced = 1'b1;
        end else if (img_h == 0) begin
          set_plain(res, RK_EMPTY, ERR_TOO_SMALL);
          produced = 1'b1;
        end else begin
          len_lo = '0;
          esc_step = '0;
          row_no = '0;
          dec_phase = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        len_lo = b;
        dec_phase = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        row_len = int'({b, len_lo});
        used = (row_len < 2) ? 2 : row_len;
        if (data_left < used) begin
          set_plain(res, RK_ERROR, ERR_END_DATA);
          produced = 1'b1;
        end else begin
          data_left = data_left - used;
          row_left = 16'(used - 2);
          budget = row_len - 4;
          col_no = '0;
          esc_step = '0;
          if (img_w == 0) begin
            if (close_row()) begin
              set_plain(res, RK_EMPTY, ERR_TOO_SMALL);
              produced = 1'b1;
            end
          end else if (budget < 1) begin
            set_plain(res, RK_ERROR, ERR_BUDGET);
            produced = 1'b1;
          end else begin
            dec_phase = ST_PIXELS;
          end
        end
      end
      ST_PIXELS: begin
        if (row_left > 0) row_left = row_left - 16'd1;
        if (esc_step == 2'd0) begin
          budget = budget - 1;
          if (b != 0) begin
            emit_pixels(b, 1, res);
            produced = 1'b1;
          end else if (budget < 2) begin
            set_plain(res, RK_ERROR, ERR_BUDGET);
            produced = 1'b1;
          end else begin
            esc_step = 2'd1;
          end
        end else if (esc_step == 2'd1) begin
          esc_val = b;
          esc_step = 2'd2;
        end else begin
          budget = budget - 2;
          esc_step = '0;
          produced = 1'b1;
          if (b == 0) set_plain(res, RK_ERROR, ERR_ZERO_COUNT);
          else emit_pixels(esc_val, int'(b), res);
        end
      end
      ST_SKIP: begin
        if (row_left > 0) row_left = row_left - 16'd1;
        if (row_left == 0) dec_phase = ST_LEN_LO;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(input bit is_new, input logic [7:0] data, input logic [23:0] total);
    feed_item_t it;
    it.is_new = is_new;
    it.data = data;
    it.total = total;
    byte_feed.push_back(it);
  endtask

  // Data bytes carry a random size field, which the decoder ignores.
  task automatic push_data(input logic [7:0] data);
    push_byte(1'b0, data, 24'($urandom));
  endtask

  // Builds one image with random rows and runs, optionally with one flaw.
  task automatic queue_image(input int width, input int height, input flaw_e flaw);
    logic [7:0] body[$];
    logic [7:0] row_bytes[$];
    int total;
    int col;
    int room;
    int cnt;
    int n;
    int len;
    int used;
    int k;
    bit zero_done;
    total = 4;
    zero_done = 1'b0;
    for (int r = 0; r < height; r++) begin
      row_bytes.delete();
      col = 0;
      while (col < width) begin
        room = width - col;
        if ($urandom_range(0, 99) < 55) begin
          row_bytes.push_back(8'($urandom_range(1, 255)));
          col++;
        end else begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                            : $urandom_range(1, room);
          if (flaw == FLAW_ZERO_COUNT && !zero_done && $urandom_range(0, 1) == 1) begin
            cnt = 0;
            zero_done = 1'b1;
          end
          row_bytes.push_back(8'd0);
          row_bytes.push_back(8'($urandom));
          row_bytes.push_back(8'(cnt));
          col += (cnt == 0) ? 1 : ((cnt < room) ? cnt : room);
        end
      end
      n = row_bytes.size();
      if (width == 0) len = $urandom_range(0, 6);
      else if (flaw == FLAW_BUDGET && r == height - 1) len = n + 4 - $urandom_range(1, 3);
      else len = n + 4 + $urandom_range(0, 3);
      used = (len < 2) ? 2 : len;
      body.push_back(8'(len));
      body.push_back(8'(len >> 8));
      foreach (row_bytes[i]) body.push_back(row_bytes[i]);
      for (k = n + 2; k < used; k++) body.push_back(8'($urandom));
      total += used;
    end
    case (flaw)
      FLAW_NONE:    if ($urandom_range(0, 9) == 0) total = 24'hFFFFFF;
      FLAW_SHORT:   total = (total > 8) ? total - $urandom_range(1, 8) : 0;
      FLAW_CORRUPT: if (body.size() > 0) body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
      FLAW_CUT:     while (body.size() > 0 && $urandom_range(0, 3) != 0) void'(body.pop_back());
      default: ;
    endcase
    push_byte(1'b1, 8'(width), 24'(total));
    if (flaw == FLAW_HEADER && $urandom_range(0, 1) == 1) begin
      push_data(8'($urandom_range(1, 255)));
      push_data(8'(height));
      push_data(HEADER_MARK);
    end else begin
      push_data(8'd0);
      push_data(8'(height));
      push_data((flaw == FLAW_HEADER) ? 8'($urandom_range(0, 127)) : HEADER_MARK);
    end
    foreach (body[i]) push_data(body[i]);
    images_made++;
  endtask

  initial begin
    int pick;
    int width;
    int height;
    int directed;
    flaw_e flaw;

    // Short resource, with the size at zero.
    push_byte(1'b1, 8'hAA, 24'd0);
    // Largest size, nonzero second header byte: bad header.
    push_byte(1'b1, 8'd5, 24'hFFFFFF);
    push_data(8'd1);
    push_data(8'd7);
    push_data(HEADER_MARK);
    // Zero height finishes at the header.
    push_byte(1'b1, 8'd3, 24'd20);
    push_data(8'd0);
    push_data(8'd0);
    push_data(HEADER_MARK);
    // Zero width with a tiny row count: one empty row ends the image.
    push_byte(1'b1, 8'd0, 24'd6);
    push_data(8'd0);
    push_data(8'd1);
    push_data(HEADER_MARK);
    push_data(8'd1);
    push_data(8'd0);
    // An image abandoned right after its header by a new resource.
    push_byte(1'b1, 8'd4, 24'd50);
    push_data(8'd0);
    push_data(8'd2);
    push_data(HEADER_MARK);
    // Two-pixel row: a single all-ones pixel, then an escaped zero value
    // with the largest count, clipped to one pixel at the row end.
    push_byte(1'b1, 8'd2, 24'd12);
    push_data(8'd0);
    push_data(8'd1);
    push_data(HEADER_MARK);
    push_data(8'd8);
    push_data(8'd0);
    push_data(8'hFF);
    push_data(8'd0);
    push_data(8'd0);
    push_data(8'hFF);
    directed = byte_feed.size();

    // Mostly well-formed images with random content, some flawed, some noise.
    while (byte_feed.size() < directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        repeat ($urandom_range(1, 4)) push_data(8'($urandom));
      end else if (pick < 10) begin
        push_byte(1'b1, 8'($urandom), ($urandom_range(0, 1) == 1) ? 24'($urandom)
                                                                 : 24'($urandom_range(0, 6)));
        repeat ($urandom_range(0, 5)) push_data(8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) width = $urandom_range(100, 255);
        else if (pick < 9) width = 0;
        else width = $urandom_range(1, 12);
        pick = $urandom_range(0, 99);
        if (pick < 5) height = 0;
        else if (pick < 10 && width < 100) height = $urandom_range(5, 24);
        else height = $urandom_range(1, 4);
        flaw = ($urandom_range(0, 99) < 70) ? FLAW_NONE
                                            : flaw_e'($urandom_range(FLAW_SHORT, FLAW_BUDGET));
        queue_image(width, height, flaw);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last byte to go in, then for every expected result.
    @(posedge clk);
    while (byte_feed.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d bytes in %0d generated images plus directed cases.", bytes_in,
             images_made);
    $display("Checked %0d pixel runs, %0d errors and %0d empty images.", runs_seen,
             errors_seen, empties_seen);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte driver
  // ---------------------------------------------------------------------------

  // Offers the next byte when the slot is free; never idles during a hold-off
  // so that the decoder backs up into its input.
  always @(posedge clk) begin
    feed_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (byte_feed.size() > 0 &&
          (hold_left > 0 || calm_window || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = byte_feed.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {nxt.total, nxt.data};
        s_axis_tuser <= nxt.is_new;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------------

  // Random back-pressure, with two long hold-offs and one calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (cycle_no == HOLD_A || cycle_no == HOLD_B) begin
        hold_left <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm_window || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Checks each result against the oldest expectation, then predicts from
  // the byte accepted at the same edge.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    bit produced;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.err = m_axis_tdata[2:0];
        got.pal = m_axis_tdata[10:3];
        got.red = m_axis_tdata[18:11];
        got.green = m_axis_tdata[26:19];
        got.blue = m_axis_tdata[34:27];
        got.run_len = m_axis_tdata[42:35];
        got.row = m_axis_tdata[50:43];
        got.col = m_axis_tdata[58:51];
        got.img_end = m_axis_tlast;
        if (pending_results.size() == 0) begin
          $error("result item with no expectation waiting (kind %0d)", got.kind);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(got.kind));
          check_field("error_code", 32'(want.err), 32'(got.err));
          check_field("palette_index", 32'(want.pal), 32'(got.pal));
          check_field("red", 32'(want.red), 32'(got.red));
          check_field("green", 32'(want.green), 32'(got.green));
          check_field("blue", 32'(want.blue), 32'(got.blue));
          check_field("run_length", 32'(want.run_len), 32'(got.run_len));
          check_field("row_number", 32'(want.row), 32'(got.row));
          check_field("start_column", 32'(want.col), 32'(got.col));
          check_field("image_end", 32'(want.img_end), 32'(got.img_end));
          check_field("tdata padding", 32'd0, 32'(m_axis_tdata[63:59]));
          case (want.kind)
            RK_RUN:   runs_seen++;
            RK_ERROR: errors_seen++;
            default:  empties_seen++;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[31:8], produced, want);
        if (produced) pending_results.push_back(want);
        bytes_in++;
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rld_pkg.sv
rtl/core/rld_front.sv
rtl/core/rld_parser.sv
rtl/core/rle_row_image_decoder.sv
tb/testbench.sv
